### rtl/prrp_pkg.sv
`default_nettype none

package prrp_pkg;

	// Default header size in bytes and the size of the summary run total.
	localparam int HDR_SIZE_DEF = 12;
	localparam int SUM_TOTAL_BYTES = 8;

	// The summary marker after reset.
	localparam logic [63:0] MARKER_RESET = '1;

	// The record length that a summary header must carry.
	localparam logic [31:0] SUM_RECORD_LEN = 32'd8;

	// Parse phases within a row.
	typedef enum logic [1:0] {
		PH_SUM_HDR,
		PH_SUM_TOTAL,
		PH_REC_HDR,
		PH_PAYLOAD
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_SHORT_ROW = 3'd1;
	localparam logic [2:0] ERR_BAD_SUMMARY = 3'd2;
	localparam logic [2:0] ERR_TRUNC_HEADER = 3'd3;
	localparam logic [2:0] ERR_BAD_RECORD = 3'd4;

endpackage

`default_nettype wire

### rtl/patch_row_record_parser_unit.sv
// A word taken at the input is held in the input register, and its result is then written
// into the result register.
// Throughput: one word per cycle if out_stall is low; parse state is updated at the same
// edge that moves a word out of the input register, so back-to-back words need no gap.
// A word that gives no result only updates the parse state.
// Reset (arst_n low, asynchronous) empties both registers, returns the parser to the
// start of a row and sets the summary marker to all ones.
`default_nettype none

module patch_row_record_parser_unit import prrp_pkg::*; #(
	parameter int HDR_SIZE = HDR_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration.
	input  wire logic        cfg_we,
	input  wire logic [63:0] cfg_wdata,
	// Input channel.
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [31:0] row_length,
	input  wire logic        row_end,
	// Result channel.
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [63:0]      target_offset,
	output logic [7:0]       payload_byte,
	output logic [63:0]      run_total,
	output logic [2:0]       error_code,
	output logic             record_last,
	output logic             row_last
);

	localparam int CNT_W = $clog2(HDR_SIZE + 1);
	localparam logic [31:0] MIN_ROW = 32'(HDR_SIZE + SUM_TOTAL_BYTES);
	localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(HDR_SIZE);
	localparam logic [CNT_W-1:0] TOTAL_LAST = CNT_W'(SUM_TOTAL_BYTES - 1);

	// Configuration register.
	logic [63:0] marker_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (cfg_we) begin
			marker_q <= cfg_wdata;
		end
	end

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] rlen_s1;
	logic        rend_s1;
	logic        adv;
	logic        go;

	// The input register moves on when the result register is empty or being taken.
	assign adv = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign go = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			rlen_s1 <= row_length;
			rend_s1 <= row_end;
		end
	end

	// Parse state.
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [63:0]       off_q, off_d;
	logic [31:0]       len_q, len_d;
	logic [31:0]       pay_q, pay_d;
	logic [63:0]       tgt_q, tgt_d;
	logic [31:0]       rbl_q, rbl_d;
	logic              failed_q, failed_d;

	// Shared decode of the word in the input register.
	logic              first;
	logic              short_err;
	logic              exhausted;
	logic              active;
	logic [31:0]       left_before;
	logic [31:0]       left_after;
	logic [CNT_W-1:0]  cnt_inc;
	logic              hdr_done;
	logic              tot_done;
	logic [63:0]       off_new;
	logic [31:0]       len_new;
	logic              sum_bad;
	logic              trunc;
	logic              rec_bad;
	logic [31:0]       pay_dec;
	logic              pay_end;
	logic [2:0]        err;
	logic              res_valid;

	always_comb begin
		first = (phase_q == PH_SUM_HDR) && (cnt_q == '0);
		left_before = first ? rlen_s1 : rbl_q;
		short_err = first && (rlen_s1 < MIN_ROW);
		exhausted = !short_err && (left_before == '0);
		active = !failed_q && !short_err && !exhausted;
		left_after = left_before - 32'd1;
		cnt_inc = cnt_q + CNT_W'(1);
		hdr_done = cnt_inc >= HDR_LEN;
		tot_done = cnt_q == TOTAL_LAST;

		// Byte lanes of the little-endian offset and length fields.
		off_new = off_q;
		len_new = len_q;
		for (int i = 0; i < 8; i++) begin
			if (cnt_q == CNT_W'(i)) begin
				off_new[8*i +: 8] = off_q[8*i +: 8] | byte_s1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (cnt_q == CNT_W'(8 + i)) begin
				len_new[8*i +: 8] = len_q[8*i +: 8] | byte_s1;
			end
		end

		sum_bad = (phase_q == PH_SUM_HDR) && hdr_done &&
			((off_new != marker_q) || (len_new != SUM_RECORD_LEN));
		trunc = (phase_q == PH_REC_HDR) && (cnt_q == '0) &&
			(left_before < 32'(HDR_SIZE));
		rec_bad = (phase_q == PH_REC_HDR) && !trunc && hdr_done &&
			((len_new == '0) || (off_new == marker_q) || (len_new > left_after));
		pay_dec = (pay_q != '0) ? pay_q - 32'd1 : '0;
		pay_end = pay_dec == '0;

		err = ERR_NONE;
		if (!failed_q) begin
			if (short_err) begin
				err = ERR_SHORT_ROW;
			end else if (active && sum_bad) begin
				err = ERR_BAD_SUMMARY;
			end else if (active && trunc) begin
				err = ERR_TRUNC_HEADER;
			end else if (active && rec_bad) begin
				err = ERR_BAD_RECORD;
			end
		end

		res_valid = (err != ERR_NONE) || (active &&
			(((phase_q == PH_SUM_TOTAL) && tot_done) || (phase_q == PH_PAYLOAD)));
	end

	// Next parse state.
	always_comb begin
		phase_d = phase_q;
		cnt_d = cnt_q;
		off_d = off_q;
		len_d = len_q;
		pay_d = pay_q;
		tgt_d = tgt_q;
		rbl_d = rbl_q;
		failed_d = failed_q;
		if (rend_s1) begin
			phase_d = PH_SUM_HDR;
			cnt_d = '0;
			off_d = '0;
			len_d = '0;
			pay_d = '0;
			tgt_d = '0;
			rbl_d = '0;
			failed_d = 1'b0;
		end else if (!failed_q) begin
			if (err != ERR_NONE || exhausted) begin
				failed_d = 1'b1;
			end else begin
				rbl_d = left_after;
				case (phase_q)
					PH_SUM_HDR: begin
						cnt_d = cnt_inc;
						off_d = off_new;
						len_d = len_new;
						if (hdr_done) begin
							phase_d = PH_SUM_TOTAL;
							cnt_d = '0;
							off_d = '0;
							len_d = '0;
						end
					end
					PH_SUM_TOTAL: begin
						cnt_d = cnt_inc;
						off_d = off_new;
						if (tot_done) begin
							phase_d = PH_REC_HDR;
							cnt_d = '0;
							off_d = '0;
							failed_d = left_after == '0;
						end
					end
					PH_REC_HDR: begin
						cnt_d = cnt_inc;
						off_d = off_new;
						len_d = len_new;
						if (hdr_done) begin
							pay_d = len_new;
							tgt_d = off_new;
							phase_d = PH_PAYLOAD;
							cnt_d = '0;
							off_d = '0;
							len_d = '0;
						end
					end
					default: begin
						tgt_d = tgt_q + 64'd1;
						pay_d = pay_dec;
						if (pay_end) begin
							phase_d = PH_REC_HDR;
							cnt_d = '0;
							failed_d = left_after == '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SUM_HDR;
			cnt_q <= '0;
			off_q <= '0;
			len_q <= '0;
			pay_q <= '0;
			tgt_q <= '0;
			rbl_q <= '0;
			failed_q <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			off_q <= off_d;
			len_q <= len_d;
			pay_q <= pay_d;
			tgt_q <= tgt_d;
			rbl_q <= rbl_d;
			failed_q <= failed_d;
		end
	end

	// Result fields for the word in the input register.
	logic [1:0]  kind_d;
	logic [63:0] target_d;
	logic [7:0]  pbyte_d;
	logic [63:0] total_d;
	logic        rec_last_d;
	logic        row_last_d;

	always_comb begin
		kind_d = KIND_PAYLOAD;
		target_d = '0;
		pbyte_d = '0;
		total_d = '0;
		rec_last_d = 1'b0;
		row_last_d = rend_s1 || (left_after == '0);
		if (err != ERR_NONE) begin
			kind_d = KIND_ERROR;
			row_last_d = 1'b1;
		end else if (phase_q == PH_SUM_TOTAL) begin
			kind_d = KIND_SUMMARY;
			total_d = off_new;
		end else begin
			target_d = tgt_q;
			pbyte_d = byte_s1;
			rec_last_d = pay_end;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			kind <= kind_d;
			target_offset <= target_d;
			payload_byte <= pbyte_d;
			run_total <= total_d;
			error_code <= err;
			record_last <= rec_last_d;
			row_last <= row_last_d;
		end
	end

	// An error result always closes the row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERROR) |-> row_last)
		else $error("error result without row_last");

	// An error code is present exactly on error results.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
		else $error("error code does not match result kind");

	// A failed row produces no results.
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && failed_q) |=> !out_valid)
		else $error("result produced after row failure");

	// The end of a row returns the parser to the start of a new row.
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && rend_s1) |=> (phase_q == PH_SUM_HDR && cnt_q == '0 && !failed_q))
		else $error("parser not reset at row end");

	// Only payload results mark the end of a record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && record_last) |-> (kind == KIND_PAYLOAD))
		else $error("record_last on a non-payload result");

endmodule

`default_nettype wire
